// File: rtl/core/dlfd_pkg.sv
// ----------------------------------------------------------------------------
// dlfd_pkg
// Shared constants and types for the delimited length frame deframer.
// ----------------------------------------------------------------------------
package dlfd_pkg;

    localparam logic [15:0] START_MARK    = 16'd16018;
    localparam logic [15:0] END_MARK      = 16'd16108;
    localparam logic [15:0] MIN_FRAME_LEN = 16'd6;

    localparam logic [2:0] ST_PAYLOAD    = 3'd0;
    localparam logic [2:0] ST_GOOD       = 3'd1;
    localparam logic [2:0] ST_BAD_START  = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_BAD_END    = 3'd4;

    // One result item as produced by the parser for one input byte.
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } dlfd_result_t;

endpackage

// File: rtl/core/delimited_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// delimited_length_frame_deframer
// Receives a byte stream, strips frame markers and length, reports status.
// ----------------------------------------------------------------------------
// Input bytes arrive on the s_ stream channel, one byte per transfer. Each
// frame is a start marker, a two-byte total length, the payload and an end
// marker, all little-endian. Payload bytes leave on the m_ channel with
// status zero; the byte that closes a frame or detects an error gives one
// status transfer with tlast high and zero data. Header bytes give nothing.
// A transfer is taken into an input register and evaluated in the next
// cycle; its result is registered in the output register once that is
// free. One byte per cycle is sustained while the receiver keeps up,
// bounded by the compare and counter update of the frame state machine.
// When the receiver stalls and the output register is full, an input byte
// that produces a result waits in the input register and s_tready drops;
// header bytes still advance. Reset clears the state machine to hunting for
// a start marker, empties both registers and sets max_frame_len to 65535.
// cfg_wr_en writes max_frame_len; the new limit applies at the next length.
// ----------------------------------------------------------------------------
module delimited_length_frame_deframer
    import dlfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic [15:0]  max_len_reg;
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    logic [2:0]   out_status_reg;
    logic         out_last_reg;
    logic         out_free;
    logic         would_emit;
    logic         advance;
    dlfd_result_t result;

    assign out_free = !out_valid_reg || m_tready;

    // The parser result depends only on the input register, the limit and its
    // state, so it tells whether this byte needs room in the output register.
    dlfd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .max_frame_len (max_len_reg),
        .result        (result)
    );

    assign would_emit = result.valid;
    assign advance    = in_valid_reg && (!would_emit || out_free);
    assign s_tready   = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= 16'hFFFF;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && result.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && result.valid)
        begin
            out_byte_reg   <= result.out_byte;
            out_status_reg <= result.status;
            out_last_reg   <= result.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/core/dlfd_parser.sv
// ----------------------------------------------------------------------------
// dlfd_parser
// Frame state machine: consumes one byte per step and gives at most one result.
// ----------------------------------------------------------------------------
module dlfd_parser
    import dlfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    input  logic [15:0]  max_frame_len,
    output dlfd_result_t result
);

    typedef enum logic [2:0] {
        PH_START_LO = 3'd0,
        PH_START_HI = 3'd1,
        PH_LEN_LO   = 3'd2,
        PH_LEN_HI   = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_END_LO   = 3'd5,
        PH_END_HI   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] word;
    logic [15:0] bytes_dec;

    assign word = {data_byte, held_byte_reg};

    always_comb
    begin
        phase_next        = phase_reg;
        held_byte_next    = held_byte_reg;
        frame_length_next = frame_length_reg;
        bytes_left_next   = bytes_left_reg;
        bytes_dec         = bytes_left_reg;
        result            = '0;

        unique case (phase_reg)
            PH_START_HI:
            begin
                if (word == START_MARK)
                begin
                    phase_next = PH_LEN_LO;
                end
                else
                begin
                    phase_next    = PH_START_LO;
                    result.valid  = 1'b1;
                    result.status = ST_BAD_START;
                    result.last   = 1'b1;
                end
            end
            PH_LEN_LO:
            begin
                held_byte_next = data_byte;
                phase_next     = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                if (word < MIN_FRAME_LEN || word > max_frame_len)
                begin
                    phase_next    = PH_START_LO;
                    result.valid  = 1'b1;
                    result.status = ST_BAD_LENGTH;
                    result.last   = 1'b1;
                end
                else
                begin
                    frame_length_next = word;
                    bytes_left_next   = word - MIN_FRAME_LEN;
                    phase_next        = (word == MIN_FRAME_LEN) ? PH_END_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (bytes_left_reg != 16'd0)
                begin
                    bytes_dec = bytes_left_reg - 16'd1;
                end
                bytes_left_next = bytes_dec;
                if (bytes_dec == 16'd0)
                begin
                    phase_next = PH_END_LO;
                end
                result.valid    = 1'b1;
                result.out_byte = data_byte;
                result.status   = ST_PAYLOAD;
            end
            PH_END_LO:
            begin
                held_byte_next = data_byte;
                phase_next     = PH_END_HI;
            end
            PH_END_HI:
            begin
                phase_next    = PH_START_LO;
                result.valid  = 1'b1;
                result.status = (word == END_MARK) ? ST_GOOD : ST_BAD_END;
                result.last   = 1'b1;
            end
            default:
            begin
                // The first start byte lands here, and the unused phase code behaves like it.
                held_byte_next = data_byte;
                phase_next     = PH_START_HI;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START_LO;
            held_byte_reg    <= 8'd0;
            frame_length_reg <= 16'd0;
            bytes_left_reg   <= 16'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            held_byte_reg    <= held_byte_next;
            frame_length_reg <= frame_length_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule

// File: verif/delimited_length_frame_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_length_frame_deframer_test
// Self-checking testbench for the frame deframer. A short directed script
// covers the marker, length and limit corner cases. Random frames follow,
// mostly well formed with random payload, mixed with broken markers and
// lengths, under several length limits. A last frame whose length equals
// the limit closes the run. Each accepted byte is run through a behavioral
// copy of the frame parser, and every output transfer is compared with the
// oldest predicted result. Both stream sides idle at random in most phases.
// ----------------------------------------------------------------------------
module delimited_length_frame_deframer_test;
    import dlfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 600000;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned MAX_GAP        = 13;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned PHASE_BYTES    = 180;
    localparam int unsigned SCRIPT_ROWS    = 26;
    localparam int unsigned MIN_LEN        = 32'(MIN_FRAME_LEN);
    localparam int unsigned LAST_FRAME_LEN = 40;

    typedef enum logic [2:0] {
        PH_START_LO = 3'd0,
        PH_START_HI = 3'd1,
        PH_LEN_LO   = 3'd2,
        PH_LEN_HI   = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_END_LO   = 3'd5,
        PH_END_HI   = 3'd6
    } parse_phase_t;

    // The status column only matters on rows marked as typed; those rows
    // close a frame or report an error, so their data is zero and tlast high.
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic [2:0] status;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        // Empty payload: a length of exactly 6 goes straight to the end marker.
        '{8'h92, 1'b0, ST_PAYLOAD}, '{8'h3E, 1'b0, ST_PAYLOAD},
        '{8'h06, 1'b0, ST_PAYLOAD}, '{8'h00, 1'b0, ST_PAYLOAD},
        '{8'hEC, 1'b0, ST_PAYLOAD}, '{8'h3E, 1'b1, ST_GOOD},
        // Two payload bytes at both extremes.
        '{8'h92, 1'b0, ST_PAYLOAD}, '{8'h3E, 1'b0, ST_PAYLOAD},
        '{8'h08, 1'b0, ST_PAYLOAD}, '{8'h00, 1'b0, ST_PAYLOAD},
        '{8'h00, 1'b0, ST_PAYLOAD}, '{8'hFF, 1'b0, ST_PAYLOAD},
        '{8'hEC, 1'b0, ST_PAYLOAD}, '{8'h3E, 1'b1, ST_GOOD},
        // Wrong start marker, judged on both bytes.
        '{8'h00, 1'b0, ST_PAYLOAD}, '{8'h00, 1'b1, ST_BAD_START},
        // Length one below the minimum.
        '{8'h92, 1'b0, ST_PAYLOAD}, '{8'h3E, 1'b0, ST_PAYLOAD},
        '{8'h05, 1'b0, ST_PAYLOAD}, '{8'h00, 1'b1, ST_BAD_LENGTH},
        // Bad end marker after an empty payload.
        '{8'h92, 1'b0, ST_PAYLOAD}, '{8'h3E, 1'b0, ST_PAYLOAD},
        '{8'h06, 1'b0, ST_PAYLOAD}, '{8'h00, 1'b0, ST_PAYLOAD},
        '{8'hFF, 1'b0, ST_PAYLOAD}, '{8'hFF, 1'b1, ST_BAD_END}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'hFFFF;

    // Typed expectation that travels with the byte on the input stream.
    logic         tag_typed = 1'b0;
    dlfd_result_t tag_result = '0;

    // Parser copy, owned by the scoreboard.
    parse_phase_t parse_phase = PH_START_LO;
    logic [7:0]   held_byte = 8'h00;
    logic [15:0]  payload_left = 16'h0000;
    logic [15:0]  length_limit = 16'hFFFF;

    dlfd_result_t pending_results [$];

    int unsigned cycles = 0;
    int unsigned failures = 0;
    int unsigned bytes_sent = 0;
    int unsigned limits_used = 0;
    int unsigned status_seen [5] = '{0, 0, 0, 0, 0};
    int unsigned drv_limit = 65535;
    logic        send_idle = 1'b1;
    logic        recv_idle = 1'b1;

    delimited_length_frame_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding.", cycles,
                     pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Advances the parser copy by one byte and gives the result it causes.
    task automatic deframe_byte(input logic [7:0] b, output logic hit,
                                output dlfd_result_t res);
        logic [15:0] word;
        word = {b, held_byte};
        hit = 1'b0;
        res = '0;
        res.valid = 1'b1;
        case (parse_phase)
            PH_START_HI:
            begin
                parse_phase = PH_START_LO;
                if (word != START_MARK)
                begin
                    hit = 1'b1;
                    res.status = ST_BAD_START;
                    res.last = 1'b1;
                end
                else
                    parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                held_byte = b;
                parse_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                if (word < MIN_FRAME_LEN || word > length_limit)
                begin
                    parse_phase = PH_START_LO;
                    hit = 1'b1;
                    res.status = ST_BAD_LENGTH;
                    res.last = 1'b1;
                end
                else
                begin
                    payload_left = word - MIN_FRAME_LEN;
                    parse_phase = (payload_left == 16'd0) ? PH_END_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (payload_left != 16'd0)
                    payload_left = payload_left - 16'd1;
                if (payload_left == 16'd0)
                    parse_phase = PH_END_LO;
                hit = 1'b1;
                res.out_byte = b;
                res.status = ST_PAYLOAD;
            end
            PH_END_LO:
            begin
                held_byte = b;
                parse_phase = PH_END_HI;
            end
            PH_END_HI:
            begin
                parse_phase = PH_START_LO;
                hit = 1'b1;
                res.last = 1'b1;
                res.status = (word == END_MARK) ? ST_GOOD : ST_BAD_END;
            end
            default:
            begin
                held_byte = b;
                parse_phase = PH_START_HI;
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
    endtask

    always @(posedge clk)
    begin : scoreboard
        logic         hit;
        dlfd_result_t res;
        dlfd_result_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                length_limit = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                deframe_byte(s_tdata, hit, res);
                if (tag_typed)
                    pending_results.push_back(tag_result);
                else if (hit)
                    pending_results.push_back(res);
            end
            if (m_tvalid && m_tready)
            begin
                if (m_tuser < 3'd5)
                    status_seen[m_tuser]++;
                if (pending_results.size() == 0)
                    note_failure($sformatf("unexpected result byte %02h status %0d last %0b",
                                           m_tdata, m_tuser, m_tlast));
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.out_byte || m_tuser !== want.status ||
                        m_tlast !== want.last)
                        note_failure($sformatf(
                            "expected byte %02h status %0d last %0b, got %02h %0d %0b",
                            want.out_byte, want.status, want.last,
                            m_tdata, m_tuser, m_tlast));
                end
            end
        end
    end

    // Receiver: draws a random stall before each result transfer while recv_idle is set.
    initial
    begin : receiver
        int unsigned stall;
        wait (rst_n);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input dlfd_result_t want);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        tag_typed <= typed;
        tag_result <= want;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic send_word(input logic [15:0] w);
        send_plain(w[7:0]);
        send_plain(w[15:8]);
    endtask

    // Stops the input and waits until every predicted result has come out
    // and any header byte still in the pipeline has settled.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        drv_limit = 32'(value);
        limits_used++;
    endtask

    // One random frame, or a broken piece of one. Every case ends with the
    // parser back at the start marker hunt, so the next frame lines up.
    task automatic send_frame();
        int unsigned kind;
        int unsigned span;
        int unsigned flen;
        int unsigned i;
        logic [15:0] word;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            word = 16'($urandom);
            if (word == START_MARK)
                word[8] = ~word[8];
            send_word(word);
            return;
        end
        send_word(START_MARK);
        if (kind < 22)
            flen = $urandom_range(0, MIN_LEN - 1);
        else if (kind < 32 && drv_limit < 65535)
            flen = $urandom_range(drv_limit + 1, 65535);
        else if (drv_limit < MIN_LEN)
            flen = $urandom_range(0, 65535);
        else
        begin
            span = drv_limit - MIN_LEN;
            if (span > 24)
                span = ($urandom_range(0, 15) == 0 && span > 300) ? 300 :
                       ($urandom_range(0, 15) == 0) ? span : 24;
            flen = MIN_LEN + $urandom_range(0, span);
        end
        send_word(flen[15:0]);
        if (flen < MIN_LEN || flen > drv_limit)
            return;
        for (i = MIN_LEN; i < flen; i++)
            send_plain(8'($urandom_range(0, 255)));
        word = END_MARK;
        if (kind >= 88)
        begin
            word = 16'($urandom);
            if (word == END_MARK)
                word[0] = ~word[0];
        end
        send_word(word);
    endtask

    initial
    begin : stimulus
        dlfd_result_t want;
        logic [15:0]  limits [8];
        int unsigned  row;
        int unsigned  p;
        int unsigned  phase_end;
        int unsigned  i;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < SCRIPT_ROWS; row++)
        begin
            want = '0;
            want.valid = 1'b1;
            want.status = SCRIPT[row].status;
            want.last = 1'b1;
            send_byte(SCRIPT[row].data, SCRIPT[row].typed, want);
        end

        // Limit lowered after the length low byte: the new value must apply
        // to the length check of the frame already in progress.
        send_word(START_MARK);
        send_plain(8'h20);
        write_limit(16'd31);
        want = '0;
        want.valid = 1'b1;
        want.status = ST_BAD_LENGTH;
        want.last = 1'b1;
        send_byte(8'h00, 1'b1, want);

        limits = '{16'd65535, 16'd6, 16'd0, 16'd5, 16'd7,
                   16'($urandom_range(8, 64)), 16'd300,
                   16'($urandom_range(65, 65534))};
        for (p = 0; p < 8; p++)
        begin
            write_limit(limits[p]);
            send_idle = (p % 4 != 1);
            recv_idle = (p % 4 != 2);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_frame();
        end

        // One frame whose length equals the limit, sent back to back.
        write_limit(16'(LAST_FRAME_LEN));
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_word(START_MARK);
        send_word(16'(LAST_FRAME_LEN));
        for (i = MIN_LEN; i < LAST_FRAME_LEN; i++)
            send_plain(8'($urandom_range(0, 255)));
        send_word(END_MARK);
        wait_drained();

        $display("Sent %0d stream bytes over %0d length limits, ending with a frame at the limit.",
                 bytes_sent, limits_used);
        $display("Results: %0d payload, %0d good, %0d bad start, %0d bad length, %0d bad end.",
                 status_seen[ST_PAYLOAD], status_seen[ST_GOOD], status_seen[ST_BAD_START],
                 status_seen[ST_BAD_LENGTH], status_seen[ST_BAD_END]);
        if (failures == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
